### design/dual_hbridge_command_with_dead_time_assert.svh
// assertion macros for the dual h-bridge command block
`ifndef DUAL_HBRIDGE_COMMAND_WITH_DEAD_TIME_ASSERT_SVH
`define DUAL_HBRIDGE_COMMAND_WITH_DEAD_TIME_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked property, masked while reset is high
`define DHB_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// clocked property, checked through reset as well
`define DHB_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define DHB_ASSERT(label, clock, reset, prop, msg)
`define DHB_ASSERT_ALWAYS(label, clock, prop, msg)
`endif

`endif

### design/dhb_pkg.sv
// types and constants shared by the dual h-bridge command block
package dhb_pkg;

  // item kinds
  typedef enum logic {
    OP_CMD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // motor direction
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  // register select, taken from paddr bit 2
  localparam logic REG_DEAD_TIME = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [7:0]  DEAD_TIME_RESET = 8'd10;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd200;

  // one input item after the input register
  typedef struct packed {
    op_t              op;
    logic signed [7:0] left_pct;
    logic signed [7:0] right_pct;
  } item_t;

  // configuration registers
  typedef struct packed {
    logic [7:0]  dead_time_ticks;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // motor state carried from item to item
  typedef struct packed {
    dir_t              left_dir;
    dir_t              right_dir;
    logic [10:0]       left_fwd;
    logic [10:0]       left_rev;
    logic [10:0]       right_fwd;
    logic [10:0]       right_rev;
    logic signed [7:0] pend_left;
    logic signed [7:0] pend_right;
    logic [7:0]        dead_count;
    logic [15:0]       idle_count;
  } state_t;

  // per-item flags
  typedef struct packed {
    logic refused;
    logic tstop;
  } flags_t;

endpackage

### design/dhb_step.sv
// next-state logic for one command or tick item
module dhb_step (
  input  dhb_pkg::item_t  item,
  input  dhb_pkg::cfg_t   cfg,
  input  dhb_pkg::state_t st,
  output dhb_pkg::state_t st_next,
  output dhb_pkg::flags_t flags
);
  import dhb_pkg::*;

  localparam logic signed [7:0] POW_MAX = 8'sd100;
  localparam logic signed [7:0] POW_MIN = -8'sd100;
  // 1024/100 as 5243/512, exact after truncation for magnitudes 0..100
  localparam logic [19:0] DUTY_RECIP = 20'd5243;

  logic signed [7:0] lp;
  logic signed [7:0] rp;
  dir_t              ldir;
  dir_t              rdir;
  logic              lrev;
  logic              rrev;
  logic [15:0]       limit;
  logic [15:0]       idle_inc;
  logic [7:0]        dc_dec;

  // saturate to plus or minus 100
  function automatic logic signed [7:0] clamp_power(input logic signed [7:0] v);
    logic signed [7:0] r;
    r = v;
    if (v > POW_MAX) r = POW_MAX;
    if (v < POW_MIN) r = POW_MIN;
    return r;
  endfunction

  function automatic dir_t sign_dir(input logic signed [7:0] p);
    dir_t d;
    d = DIR_STOP;
    if (p > 8'sd0) d = DIR_FWD;
    if (p < 8'sd0) d = DIR_REV;
    return d;
  endfunction

  // duty magnitude |p|*1024/100 for a clamped power
  function automatic logic [10:0] duty_of(input logic signed [7:0] p);
    logic [7:0]  neg;
    logic [6:0]  mag;
    logic [19:0] prod;
    neg  = 8'(-p);
    mag  = p[7] ? neg[6:0] : p[6:0];
    prod = {13'd0, mag} * DUTY_RECIP;
    return prod[19:9];
  endfunction

  function automatic logic reverses(input dir_t old_dir, input dir_t new_dir);
    return (old_dir != DIR_STOP) && (new_dir != DIR_STOP) && (old_dir != new_dir);
  endfunction

  // load both motors from a pair of clamped powers
  function automatic state_t apply_powers(input state_t s, input logic signed [7:0] pl,
                                          input logic signed [7:0] pr);
    state_t r;
    logic [10:0] ml;
    logic [10:0] mr;
    r  = s;
    ml = duty_of(pl);
    mr = duty_of(pr);
    r.left_fwd   = (pl > 8'sd0) ? ml : 11'd0;
    r.left_rev   = (pl < 8'sd0) ? ml : 11'd0;
    r.right_fwd  = (pr > 8'sd0) ? mr : 11'd0;
    r.right_rev  = (pr < 8'sd0) ? mr : 11'd0;
    r.left_dir   = sign_dir(pl);
    r.right_dir  = sign_dir(pr);
    r.idle_count = 16'd0;
    return r;
  endfunction

  // decoded command fields
  assign lp    = clamp_power(item.left_pct);
  assign rp    = clamp_power(item.right_pct);
  assign ldir  = sign_dir(lp);
  assign rdir  = sign_dir(rp);
  assign lrev  = reverses(st.left_dir, ldir);
  assign rrev  = reverses(st.right_dir, rdir);
  assign limit = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
  assign idle_inc = (st.idle_count != 16'hFFFF) ? st.idle_count + 16'd1 : st.idle_count;
  assign dc_dec   = st.dead_count - 8'd1;

  // command and tick handling
  always_comb begin
    st_next       = st;
    flags.refused = 1'b0;
    flags.tstop   = 1'b0;
    case (item.op)
      OP_CMD: begin
        if (st.dead_count != 8'd0) begin
          flags.refused = 1'b1;
        end else begin
          if (lrev) begin
            st_next.left_fwd = 11'd0;
            st_next.left_rev = 11'd0;
          end
          if (rrev) begin
            st_next.right_fwd = 11'd0;
            st_next.right_rev = 11'd0;
          end
          if ((lrev || rrev) && (cfg.dead_time_ticks != 8'd0)) begin
            st_next.pend_left  = lp;
            st_next.pend_right = rp;
            st_next.dead_count = cfg.dead_time_ticks;
            st_next.idle_count = 16'd0;
          end else begin
            st_next = apply_powers(st_next, lp, rp);
          end
        end
      end
      OP_TICK: begin
        if (st.dead_count != 8'd0) begin
          st_next.dead_count = dc_dec;
          if (dc_dec == 8'd0) begin
            st_next = apply_powers(st_next, st.pend_left, st.pend_right);
          end
        end else if (idle_inc >= limit) begin
          st_next.idle_count = 16'd0;
          if ((st.left_dir != DIR_STOP) || (st.right_dir != DIR_STOP)) begin
            st_next.left_fwd  = 11'd0;
            st_next.left_rev  = 11'd0;
            st_next.right_fwd = 11'd0;
            st_next.right_rev = 11'd0;
            st_next.left_dir  = DIR_STOP;
            st_next.right_dir = DIR_STOP;
            flags.tstop       = 1'b1;
          end
        end else begin
          st_next.idle_count = idle_inc;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

endmodule

### design/dual_hbridge_command_with_dead_time.sv
// top level of the dual h-bridge command block with reversal dead time
//
// Input channel: in_valid / in_stall with op, left_pct, right_pct. An op of
// 0 is a motor command with a signed power percent per motor, an op of 1 is a
// one-millisecond tick. Every item gives exactly one result transfer on the
// output channel (out_valid / out_stall): the four duties after the item, the
// dead-time flag, and the refused and timeout-stop flags of that item.
// Each item passes through the input register, then the state update and the
// result register load happen together as the held item moves on.
// Throughput is one item per cycle while the receiver does not stall; the
// motor state is updated in the same cycle as the held item moves into the
// result register.
// When the receiver stalls, the result register holds and the held item waits;
// in_stall rises only once both are full, so one more item is taken while a
// finished result waits.
// Reset clears both motors to stopped with zero duties, ends any dead time,
// empties both stages and loads dead_time_ticks = 10, timeout_ticks = 200.
// Registers over APB: dead_time_ticks at 0x0, timeout_ticks at 0x4; pready is
// always high and writes are expected only while the block is idle.
module dual_hbridge_command_with_dead_time (
  input  logic                         clk,
  input  logic                         rst,
  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dhb_pkg::ADDR_W-1:0]   paddr,
  input  logic [dhb_pkg::DATA_W-1:0]   pwdata,
  output logic [dhb_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic signed [7:0]            left_pct,
  input  logic signed [7:0]            right_pct,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [10:0]                  left_fwd_duty,
  output logic [10:0]                  left_rev_duty,
  output logic [10:0]                  right_fwd_duty,
  output logic [10:0]                  right_rev_duty,
  output logic                         dead_time_active,
  output logic                         command_refused,
  output logic                         timeout_stop
);
  import dhb_pkg::*;

  `include "dual_hbridge_command_with_dead_time_assert.svh"

  cfg_t   cfg;
  item_t  held;
  logic   held_valid;
  state_t st;
  state_t st_next;
  flags_t flags;
  logic   in_xfer;
  logic   held_go;
  logic   cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_time_ticks <= DEAD_TIME_RESET;
      cfg.timeout_ticks   <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DEAD_TIME: cfg.dead_time_ticks <= pwdata[7:0];
        REG_TIMEOUT:   cfg.timeout_ticks   <= pwdata[15:0];
        default:       cfg <= cfg;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      REG_DEAD_TIME: prdata = {24'd0, cfg.dead_time_ticks};
      REG_TIMEOUT:   prdata = {16'd0, cfg.timeout_ticks};
      default:       prdata = '0;
    endcase
  end

  // handshake between the two stages
  assign held_go  = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && !held_go;
  assign in_xfer  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_xfer) begin
      held_valid <= 1'b1;
    end else if (held_go) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      held.op        <= op_t'(op);
      held.left_pct  <= left_pct;
      held.right_pct <= right_pct;
    end
  end

  // per-item state update
  dhb_step u_step (
    .item    (held),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .flags   (flags)
  );

  // motor state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (held_go) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (held_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (held_go) begin
      left_fwd_duty    <= st_next.left_fwd;
      left_rev_duty    <= st_next.left_rev;
      right_fwd_duty   <= st_next.right_fwd;
      right_rev_duty   <= st_next.right_rev;
      dead_time_active <= (st_next.dead_count != 8'd0);
      command_refused  <= flags.refused;
      timeout_stop     <= flags.tstop;
    end
  end

  // checks
  `DHB_ASSERT(a_left_one_side, clk, rst, (st.left_fwd == 11'd0) || (st.left_rev == 11'd0), "left motor driven both ways")
  `DHB_ASSERT(a_right_one_side, clk, rst, (st.right_fwd == 11'd0) || (st.right_rev == 11'd0), "right motor driven both ways")
  `DHB_ASSERT(a_refused_in_pause, clk, rst, out_valid && command_refused |-> dead_time_active, "refused outside dead time")
  `DHB_ASSERT(a_stall_freezes_state, clk, rst, out_valid && out_stall |=> $stable(st), "state moved under output stall")
  `DHB_ASSERT(a_timeout_zero, clk, rst, out_valid && timeout_stop |-> (left_fwd_duty == 11'd0) && (left_rev_duty == 11'd0) && (right_fwd_duty == 11'd0) && (right_rev_duty == 11'd0), "duty left after timeout stop")

endmodule
